>>> rtl/fixed_timestep_tick_clock_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the fixed-timestep tick clock
// Shared property forms for the checker; each use names its own label.
// -----------------------------------------------------------------------------
`ifndef FIXED_TIMESTEP_TICK_CLOCK_ASSERT_SVH
`define FIXED_TIMESTEP_TICK_CLOCK_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define FTCLK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ftclk assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define FTCLK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ftclk assertion failed");

`endif

>>> rtl/ftclk_pkg.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick clock package
// Item kinds, register indexes, fixed-point constants and reset values.
// -----------------------------------------------------------------------------
package ftclk_pkg;

	localparam int FRAC_BITS       = 32;
	localparam int TOLERANCE_UNITS = 4;
	localparam int ALPHA_SHIFT     = FRAC_BITS - 16;

	localparam int KIND_W  = 2;
	localparam int DELTA_W = 40;
	localparam int ACC_W   = 40;
	localparam int TICK_W  = 32;
	localparam int STEP_W  = 32;
	localparam int RATE_W  = 16;
	localparam int IVAL_W  = 16;
	localparam int TIME_W  = 64;
	localparam int ALPHA_W = 17;
	localparam int CFG_W   = 40;
	localparam int CIDX_W  = 2;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 2;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	localparam logic [RATE_W-1:0] TICK_RATE_RST      = 16'd60;
	localparam logic [STEP_W-1:0] FIXED_STEP_RST     = 32'd71582788;
	localparam logic [IVAL_W-1:0] SNAP_INTERVAL_RST  = 16'd3;
	localparam logic [ACC_W-1:0]  MAX_ACCUM_RST      = 40'd1073741824;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_TICK_RATE  = 2'd0,
		REG_FIXED_STEP = 2'd1,
		REG_SNAP_IVAL  = 2'd2,
		REG_MAX_ACCUM  = 2'd3
	} cfg_reg_t;

	// Output tuser bit positions
	localparam int USER_TICKED = 0;
	localparam int USER_DUE    = 1;

endpackage

>>> rtl/fixed_timestep_tick_clock.sv
// An accepted item is held in stage 1, its new state in stage 2, its result in stage 3.
// Throughput: one item per cycle while the output is not stalled; the state update (one
// add, compare and subtract on the accumulator) sets the rate, the two products sit in the next stage.
// Each stage advances on its own, so input is taken while a result waits at the output.
// Reset (arst_n low, asynchronous): config returns to its defaults, accumulator and
// tick counter clear, the snapshot countdown loads the default interval, stages empty.
// -----------------------------------------------------------------------------
// Fixed-timestep tick clock
// Accumulates frame time, issues fixed steps and reports time, alpha and snapshots.
// -----------------------------------------------------------------------------
module fixed_timestep_tick_clock
	import ftclk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CIDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// Item input
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DELTA_W-1:0]    s_axis_tdata,   // [39:0] frame_delta
	input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
	// Result output
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] tick_count, [95:32] sim_time,
	                                              // [112:96] alpha, [119:113] zero
	output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] ticked, [1] snapshot_due
);

	// Configuration registers
	logic [RATE_W-1:0] tick_rate_q;
	logic [STEP_W-1:0] fixed_step_q;
	logic [IVAL_W-1:0] snap_ival_q;
	logic [ACC_W-1:0]  max_accum_q;

	// Clock state
	logic [ACC_W-1:0]  accum_q;
	logic [TICK_W-1:0] tick_q;
	logic [IVAL_W-1:0] countdown_q;

	// Stage 1: registered input item
	logic               valid_s1;
	kind_t              kind_s1;
	logic [DELTA_W-1:0] delta_s1;

	// Stage 2: state after the item
	logic              valid_s2;
	logic [ACC_W-1:0]  accum_s2;
	logic [TICK_W-1:0] tick_s2;
	logic              ticked_s2;
	logic              due_s2;

	// Stage 3: result register
	logic                  valid_s3;
	logic [OUT_DATA_W-1:0] data_s3;
	logic [OUT_USER_W-1:0] user_s3;

	// Handshake: each stage fills when it is empty or its content moves on
	logic ready_s3, ready_s2, ready_s1;
	logic adv_s1, adv_s2, adv_s3;

	assign ready_s3 = !valid_s3 || m_axis_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s1   = s_axis_tvalid && ready_s1;
	assign adv_s2   = valid_s1 && ready_s2;
	assign adv_s3   = valid_s2 && ready_s3;

	assign s_axis_tready = ready_s1;
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = data_s3;
	assign m_axis_tuser  = user_s3;

	// Zero interval behaves as one
	logic [IVAL_W-1:0] ival_eff;
	logic [IVAL_W-1:0] ival_wr_eff;

	assign ival_eff    = (snap_ival_q == '0) ? IVAL_W'(1) : snap_ival_q;
	assign ival_wr_eff = (cfg_data[IVAL_W-1:0] == '0) ? IVAL_W'(1) : cfg_data[IVAL_W-1:0];

	// Next state for the item in stage 1
	logic [ACC_W:0]    add_sum;
	logic [ACC_W:0]    acc_tol;
	logic              step_ok;
	logic [ACC_W-1:0]  accum_nxt;
	logic [TICK_W-1:0] tick_nxt;
	logic [IVAL_W-1:0] countdown_nxt;
	logic              ticked_nxt;
	logic              due_nxt;

	assign add_sum = {1'b0, accum_q} + {1'b0, delta_s1};
	assign acc_tol = {1'b0, accum_q} + (ACC_W+1)'(TOLERANCE_UNITS);
	assign step_ok = acc_tol >= {(ACC_W+1-STEP_W)'(0), fixed_step_q};

	always_comb begin
		accum_nxt     = accum_q;
		tick_nxt      = tick_q;
		countdown_nxt = countdown_q;
		ticked_nxt    = 1'b0;
		due_nxt       = 1'b0;
		case (kind_s1)
			KIND_ADD: begin
				// Ignore zero and negative deltas, clamp the sum at the limit
				if (!delta_s1[DELTA_W-1] && delta_s1 != '0) begin
					if (add_sum > {1'b0, max_accum_q}) begin
						accum_nxt = max_accum_q;
					end else begin
						accum_nxt = add_sum[ACC_W-1:0];
					end
				end
			end
			KIND_TICK: begin
				if (step_ok) begin
					// Within tolerance but short of a full step: drop to zero
					if (accum_q >= {(ACC_W-STEP_W)'(0), fixed_step_q}) begin
						accum_nxt = accum_q - {(ACC_W-STEP_W)'(0), fixed_step_q};
					end else begin
						accum_nxt = '0;
					end
					tick_nxt   = tick_q + TICK_W'(1);
					ticked_nxt = 1'b1;
					if (countdown_q <= IVAL_W'(1)) begin
						countdown_nxt = ival_eff;
						due_nxt       = (tick_nxt != '0);
					end else begin
						countdown_nxt = countdown_q - IVAL_W'(1);
					end
				end
			end
			KIND_CLEAR: begin
				accum_nxt     = '0;
				tick_nxt      = '0;
				countdown_nxt = ival_eff;
			end
			default: begin
				// Unused kind: hold everything
			end
		endcase
	end

	// Config and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q  <= TICK_RATE_RST;
			fixed_step_q <= FIXED_STEP_RST;
			snap_ival_q  <= SNAP_INTERVAL_RST;
			max_accum_q  <= MAX_ACCUM_RST;
			accum_q      <= '0;
			tick_q       <= '0;
			countdown_q  <= SNAP_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TICK_RATE:  tick_rate_q  <= cfg_data[RATE_W-1:0];
				REG_FIXED_STEP: fixed_step_q <= cfg_data[STEP_W-1:0];
				REG_SNAP_IVAL: begin
					snap_ival_q <= cfg_data[IVAL_W-1:0];
					countdown_q <= ival_wr_eff;
				end
				REG_MAX_ACCUM:  max_accum_q  <= cfg_data[ACC_W-1:0];
				default: begin
				end
			endcase
		end else if (adv_s2) begin
			// Commit the item's state change as it leaves stage 1; a config write takes priority
			accum_q     <= accum_nxt;
			tick_q      <= tick_nxt;
			countdown_q <= countdown_nxt;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_axis_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Products of the post-item state
	logic [TIME_W-1:0]        sim_time;
	logic [ACC_W+RATE_W-1:0]  alpha_prod;
	logic [ACC_W+RATE_W-1:0]  alpha_full;
	logic [ALPHA_W-1:0]       alpha;
	logic [RATE_W-1:0]        rate_eff;

	assign rate_eff   = (tick_rate_q == '0) ? RATE_W'(1) : tick_rate_q;
	assign sim_time   = TIME_W'(tick_s2) * TIME_W'(fixed_step_q);
	assign alpha_prod = (ACC_W+RATE_W)'(accum_s2) * (ACC_W+RATE_W)'(rate_eff);
	assign alpha_full = alpha_prod >> ALPHA_SHIFT;
	assign alpha      = (alpha_full > (ACC_W+RATE_W)'(ALPHA_ONE)) ? ALPHA_ONE
	                                                              : alpha_full[ALPHA_W-1:0];

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1  <= kind_t'(s_axis_tuser);
			delta_s1 <= s_axis_tdata;
		end
		if (adv_s2) begin
			accum_s2  <= accum_nxt;
			tick_s2   <= tick_nxt;
			ticked_s2 <= ticked_nxt;
			due_s2    <= due_nxt;
		end
		if (adv_s3) begin
			data_s3 <= {(OUT_DATA_W-ALPHA_W-TIME_W-TICK_W)'(0), alpha, sim_time, tick_s2};
			user_s3 <= {due_s2, ticked_s2};
		end
	end

endmodule

>>> rtl/ftclk_checker.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick clock port checker
// Watches the result channel of the top level and is bound to it below.
// -----------------------------------------------------------------------------
`include "fixed_timestep_tick_clock_assert.svh"

module ftclk_checker
	import ftclk_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	// Short names for the watched result fields
	logic                             out_stall;
	logic                             out_snap;
	logic [OUT_USER_W+OUT_DATA_W-1:0] out_word;
	logic [TICK_W-1:0]                out_tick;
	logic [ALPHA_W-1:0]               out_alpha;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_snap  = m_axis_tvalid && m_axis_tuser[USER_DUE];
	assign out_word  = {m_axis_tuser, m_axis_tdata};
	assign out_tick  = m_axis_tdata[TICK_W-1:0];
	assign out_alpha = m_axis_tdata[TICK_W+TIME_W +: ALPHA_W];

	// Hold a stalled result unchanged
	`FTCLK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))

	// A snapshot only comes with a tick
	`FTCLK_ASSERT_SAME(a_due_ticked, clk, arst_n, out_snap, m_axis_tuser[USER_TICKED])

	// A snapshot never reports tick zero
	`FTCLK_ASSERT_SAME(a_due_nonzero, clk, arst_n, out_snap, out_tick != '0)

	// Alpha never exceeds one
	`FTCLK_ASSERT_SAME(a_alpha_clamp, clk, arst_n, m_axis_tvalid, out_alpha <= ALPHA_ONE)

endmodule

bind fixed_timestep_tick_clock ftclk_checker u_ftclk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/fixed_timestep_tick_clock_tb.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick clock testbench
// Drives add-delta, consume, clear and unused items through the stream input,
// predicts each result from a local copy of the accumulator, tick counter and
// snapshot countdown, and checks every result field in order. The run covers
// six register settings, from the reset defaults to the zero and all-ones
// extremes. Each setting uses one of three backpressure mixes on the two sides.
// -----------------------------------------------------------------------------
module fixed_timestep_tick_clock_tb;
	import ftclk_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;   // cycles with no transaction on either side
	localparam int NUM_SETTINGS = 6;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		kind_t              kind;
		logic [DELTA_W-1:0] delta;
	} clock_item_t;

	typedef struct packed {
		logic               ticked;
		logic [TICK_W-1:0]  tick_count;
		logic [TIME_W-1:0]  sim_time;
		logic [ALPHA_W-1:0] alpha;
		logic               snapshot_due;
	} tick_report_t;

	// DUT ports; every input holds a known value from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CIDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DELTA_W-1:0]    s_axis_tdata = '0;     // [39:0] frame_delta
	logic [KIND_W-1:0]     s_axis_tuser = '0;     // [1:0] kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;          // [31:0] tick_count, [95:32] sim_time,
	                                              // [112:96] alpha, [119:113] zero
	logic [OUT_USER_W-1:0] m_axis_tuser;          // [0] ticked, [1] snapshot_due

	// Predicted clock: register copies and state, starting from the reset values
	logic [RATE_W-1:0] cfg_rate     = TICK_RATE_RST;
	logic [STEP_W-1:0] cfg_step     = FIXED_STEP_RST;
	logic [IVAL_W-1:0] cfg_ival     = SNAP_INTERVAL_RST;
	logic [ACC_W-1:0]  cfg_max_acc  = MAX_ACCUM_RST;
	logic [ACC_W-1:0]  accum        = '0;
	logic [TICK_W-1:0] tick_total   = '0;
	logic [IVAL_W-1:0] snap_countdown = SNAP_INTERVAL_RST;

	clock_item_t  pending_items[$];
	tick_report_t expected_reports[$];
	clock_item_t  next_item;
	tick_report_t got_report;
	tick_report_t want_report;

	int send_idle_pct = 32;
	int sink_idle_pct = 83;
	int items_accepted = 0;
	int reports_seen = 0;
	int ticks_seen = 0;
	int snapshots_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	fixed_timestep_tick_clock i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A zero interval register behaves as one
	function automatic logic [IVAL_W-1:0] snapshot_period();
		return (cfg_ival == '0) ? IVAL_W'(1) : cfg_ival;
	endfunction

	// Advance the predicted clock by one item and return the report it produces
	function automatic tick_report_t advance_clock(kind_t kind, logic [DELTA_W-1:0] delta);
		tick_report_t       rep;
		logic [ACC_W:0]     sum;
		logic [55:0]        scaled;
		logic [ACC_W-1:0]   shifted;
		logic [RATE_W-1:0]  rate;
		rep = '0;
		case (kind)
			KIND_ADD: begin
				// zero and negative deltas leave the accumulator alone
				if (!delta[DELTA_W-1] && delta != '0) begin
					sum = {1'b0, accum} + {1'b0, delta};
					accum = (sum > {1'b0, cfg_max_acc}) ? cfg_max_acc : sum[ACC_W-1:0];
				end
			end
			KIND_TICK: begin
				// a step within tolerance of the accumulator still ticks, clamping at zero
				if ({1'b0, accum} + (ACC_W+1)'(TOLERANCE_UNITS) >= (ACC_W+1)'(cfg_step)) begin
					accum = (accum >= ACC_W'(cfg_step)) ? accum - ACC_W'(cfg_step) : '0;
					tick_total = tick_total + 1'b1;
					rep.ticked = 1'b1;
					if (snap_countdown <= IVAL_W'(1)) begin
						snap_countdown = snapshot_period();
						rep.snapshot_due = (tick_total != '0);
					end else begin
						snap_countdown = snap_countdown - 1'b1;
					end
				end
			end
			KIND_CLEAR: begin
				tick_total = '0;
				accum = '0;
				snap_countdown = snapshot_period();
			end
			default: ;
		endcase
		rate = (cfg_rate == '0) ? RATE_W'(1) : cfg_rate;
		scaled = 56'(accum) * 56'(rate);
		shifted = ACC_W'(scaled >> ALPHA_SHIFT);
		rep.tick_count = tick_total;
		rep.sim_time = TIME_W'(tick_total) * TIME_W'(cfg_step);
		rep.alpha = (shifted > ACC_W'(ALPHA_ONE)) ? ALPHA_ONE : shifted[ALPHA_W-1:0];
		return rep;
	endfunction

	// Frame deltas shaped around the current step so that consumes really tick,
	// with zero, negative and fully random deltas mixed in
	function automatic logic [DELTA_W-1:0] random_frame_delta();
		logic [DELTA_W-1:0] d;
		case ($urandom_range(9))
			0: d = '0;
			1: d = {1'b1, 7'($urandom), $urandom};
			2: d = {8'($urandom), $urandom};
			3: d = DELTA_W'(cfg_step) - DELTA_W'($urandom_range(8));
			default: d = ((DELTA_W'(cfg_step) * DELTA_W'($urandom_range(1, 4)))
			              >> $urandom_range(2)) + DELTA_W'($urandom_range(15));
		endcase
		return d;
	endfunction

	task automatic push_item(kind_t kind, logic [DELTA_W-1:0] delta);
		clock_item_t it;
		it.kind = kind;
		it.delta = delta;
		pending_items.push_back(it);
	endtask

	// Queue a batch of random items: mostly adds and consumes, some clears and unused kinds
	task automatic queue_random_items(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				push_item(KIND_ADD, random_frame_delta());
			else if (pick < 88)
				push_item(KIND_TICK, {8'($urandom), $urandom});
			else if (pick < 94)
				push_item(KIND_CLEAR, {8'($urandom), $urandom});
			else
				push_item(KIND_NONE, {8'($urandom), $urandom});
		end
	endtask

	// Hold until every queued item has been taken and every result has come back
	task automatic wait_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Write one register and mirror it in the predicted clock; only called while idle
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_TICK_RATE:  cfg_rate = value[RATE_W-1:0];
			REG_FIXED_STEP: cfg_step = value[STEP_W-1:0];
			REG_SNAP_IVAL: begin
				cfg_ival = value[IVAL_W-1:0];
				snap_countdown = snapshot_period();
			end
			default:        cfg_max_acc = value[ACC_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic note_failure(string why, tick_report_t want, tick_report_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t: %s", $realtime, why);
			$display("  expected ticked=%0d tick=%0d time=%h alpha=%h due=%0d",
			         want.ticked, want.tick_count, want.sim_time, want.alpha, want.snapshot_due);
			$display("  actual   ticked=%0d tick=%0d time=%h alpha=%h due=%0d pad=%h",
			         got.ticked, got.tick_count, got.sim_time, got.alpha, got.snapshot_due,
			         m_axis_tdata[OUT_DATA_W-1:96+ALPHA_W]);
		end
	endtask

	// Item driver: predict on each accepted transaction, then present the next item
	// or drop valid when the queue is empty or this cycle idles
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_reports.push_back(advance_clock(kind_t'(s_axis_tuser), s_axis_tdata));
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_item.kind;
					s_axis_tdata <= next_item.delta;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: randomize ready, compare every accepted result with the
	// oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				reports_seen++;
				got_report.ticked       = m_axis_tuser[USER_TICKED];
				got_report.snapshot_due = m_axis_tuser[USER_DUE];
				got_report.tick_count   = m_axis_tdata[31:0];
				got_report.sim_time     = m_axis_tdata[95:32];
				got_report.alpha        = m_axis_tdata[96 +: ALPHA_W];
				if (got_report.ticked)
					ticks_seen++;
				if (got_report.snapshot_due)
					snapshots_seen++;
				if (expected_reports.size() == 0) begin
					note_failure("result with no item outstanding", '0, got_report);
				end else begin
					want_report = expected_reports.pop_front();
					if (got_report.ticked !== want_report.ticked
					    || got_report.tick_count !== want_report.tick_count
					    || got_report.sim_time !== want_report.sim_time
					    || got_report.alpha !== want_report.alpha
					    || got_report.snapshot_due !== want_report.snapshot_due
					    || m_axis_tdata[OUT_DATA_W-1:96+ALPHA_W] !== '0)
						note_failure("result mismatch", want_report, got_report);
				end
			end
		end
	end

	// Watchdog: end the run when neither side moves a transaction for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
				$display("FAIL fixed_timestep_tick_clock");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset defaults
		push_item(KIND_TICK, '0);                            // empty accumulator, no tick
		push_item(KIND_ADD, '0);                             // zero delta ignored
		push_item(KIND_ADD, 40'hFF_FFFF_FFFF);               // minus one ignored
		push_item(KIND_ADD, 40'h80_0000_0000);               // most negative ignored
		push_item(KIND_ADD, 40'h7F_FFFF_FFFF);               // saturate, alpha clamps to one
		push_item(KIND_TICK, '0);
		push_item(KIND_TICK, '0);
		push_item(KIND_TICK, '0);                            // third tick raises snapshot
		push_item(KIND_NONE, 40'h55_5555_5555);              // unused kind
		push_item(KIND_CLEAR, 40'hAA_AAAA_AAAA);
		push_item(KIND_ADD, DELTA_W'(FIXED_STEP_RST) - 2);   // step just above accumulator
		push_item(KIND_TICK, '0);                            // ticks on tolerance, clamps to zero
		push_item(KIND_ADD, DELTA_W'(FIXED_STEP_RST) - 5);   // outside tolerance
		push_item(KIND_TICK, '0);                            // no tick
		push_item(KIND_ADD, 40'd5);                          // exactly one step
		push_item(KIND_TICK, '0);
		push_item(KIND_ADD, 40'd1);                          // smallest positive delta
		push_item(KIND_TICK, '0);
		push_item(KIND_CLEAR, '0);
		push_item(KIND_NONE, 40'hFF_FFFF_FFFF);

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s > 0) begin
				wait_drained();
				case (s)
					1: begin                                 // smallest step and limit
						write_reg(REG_TICK_RATE, 40'd65535);
						write_reg(REG_FIXED_STEP, 40'd1);
						write_reg(REG_SNAP_IVAL, 40'd1);
						write_reg(REG_MAX_ACCUM, 40'd1);
					end
					2: begin                                 // largest step and limit
						write_reg(REG_TICK_RATE, 40'd1);
						write_reg(REG_FIXED_STEP, 40'hFFFF_FFFF);
						write_reg(REG_SNAP_IVAL, 40'd65535);
						write_reg(REG_MAX_ACCUM, 40'hFF_FFFF_FFFF);
					end
					3: begin                                 // frequent ticks, tight limit
						write_reg(REG_TICK_RATE, 40'd1000);
						write_reg(REG_FIXED_STEP, 40'd1000);
						write_reg(REG_SNAP_IVAL, 40'd2);
						write_reg(REG_MAX_ACCUM, 40'd5000);
					end
					4: begin                                 // all registers zero
						write_reg(REG_TICK_RATE, 40'd0);
						write_reg(REG_FIXED_STEP, 40'd0);
						write_reg(REG_SNAP_IVAL, 40'd0);
						write_reg(REG_MAX_ACCUM, 40'd0);
					end
					default: begin                           // 30 Hz clock
						write_reg(REG_TICK_RATE, 40'd30);
						write_reg(REG_FIXED_STEP, 40'd143165577);
						write_reg(REG_SNAP_IVAL, 40'd5);
						write_reg(REG_MAX_ACCUM, 40'h00_FFFF_FFFF);
					end
				endcase
			end
			// sender light and receiver heavy, then swapped, then free flow
			if (s < 2) begin
				send_idle_pct = 32;
				sink_idle_pct = 83;
			end else if (s < 4) begin
				send_idle_pct = 83;
				sink_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				sink_idle_pct = 0;
			end
			queue_random_items(60);
			wait_drained();                                  // sender holds until all results are in
			queue_random_items(65);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_reports.size() != 0)
			mismatches++;
		$display("Ran %0d items over %0d register settings: %0d results, %0d ticks, %0d snapshots.",
		         items_accepted, NUM_SETTINGS, reports_seen, ticks_seen, snapshots_seen);
		$display("Failures: %0d, results still outstanding: %0d.",
		         mismatches, expected_reports.size());
		if (mismatches == 0)
			$display("PASS fixed_timestep_tick_clock");
		else
			$display("FAIL fixed_timestep_tick_clock");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/ftclk_pkg.sv
rtl/fixed_timestep_tick_clock.sv
rtl/ftclk_checker.sv
tb/sv/fixed_timestep_tick_clock_tb.sv
